>>> hw/rtl/lis_pkg.sv
// ----------------------------------------------------------------------------
// lis_pkg
// Shared widths and constants for the loop interval statistics monitor.
// ----------------------------------------------------------------------------
package lis_pkg;

    // default timer width
    localparam int TIMER_WIDTH_DEF = 32;

    // statistic and register widths
    localparam int IV_W   = 32;
    localparam int CAP_W  = 10;
    localparam int N_W    = CAP_W + 1;
    // count*average + interval + n/2 stays below 2^43
    localparam int SUM_W  = IV_W + N_W;
    localparam int STEP_W = $clog2(SUM_W);

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1000);
    localparam logic [IV_W-1:0]  IV_ONES   = '1;

    typedef logic [IV_W-1:0]  iv_t;
    typedef logic [CAP_W-1:0] cap_t;
    typedef logic [N_W-1:0]   n_t;
    typedef logic [SUM_W-1:0] sum_t;

endpackage

>>> hw/rtl/loop_interval_statistics.sv
// ----------------------------------------------------------------------------
// loop_interval_statistics
// Interval, max, min and rounded running average of free-running timer reads.
// ----------------------------------------------------------------------------
// Each accepted word carries a timer reading. The block returns one word
// holding the interval since the previous reading (modulo the timer width,
// saturated to 32 bits), the largest and smallest intervals since reset, and
// the rounded running average whose weight is capped by the cap register.
// One item is handled at a time: accept, then bias, shift-add multiply and
// restoring divide on one shared 43-bit adder, then the result is held
// until taken. The next word is accepted only after the result has been
// taken. The cap register may be written only while the block is idle.
module loop_interval_statistics
    import lis_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
)(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration
    input  logic                   cfg_wr_en,
    input  logic [CAP_W-1:0]       cfg_wr_data,
    // input channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [TIMER_WIDTH-1:0] timer_now,
    // output channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [IV_W-1:0]        interval,
    output logic [IV_W-1:0]        interval_max,
    output logic [IV_W-1:0]        interval_min,
    output logic [IV_W-1:0]        interval_average
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_BIAS = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(CAP_W - 1);
    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(SUM_W - 1);

    logic [2:0]             state_reg, state_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    cap_t                   cap_reg;
    logic [TIMER_WIDTH-1:0] prev_reg;
    cap_t                   count_reg;
    iv_t                    avg_reg, avg_next;
    iv_t                    max_reg, min_reg;
    iv_t                    iv_reg;
    n_t                     n_reg;
    cap_t                   mplier_reg, mplier_next;
    sum_t                   mcand_reg, mcand_next;
    sum_t                   acc_reg, acc_next;
    n_t                     rem_reg, rem_next;

    logic [TIMER_WIDTH-1:0] diff;
    iv_t                    iv_sat;
    logic                   accept;
    cap_t                   cap_eff;
    n_t                     n_new;
    cap_t                   count_new;

    // shared adder
    sum_t                   alu_a, alu_b;
    logic                   alu_sub;
    logic [SUM_W:0]         alu_res;
    logic                   alu_carry;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    assign interval         = iv_reg;
    assign interval_max     = max_reg;
    assign interval_min     = min_reg;
    assign interval_average = avg_reg;

    // interval modulo timer width, saturated to 32 bits
    assign diff = timer_now - prev_reg;
    generate
        if (TIMER_WIDTH > IV_W) begin : g_sat
            assign iv_sat = (|diff[TIMER_WIDTH-1:IV_W]) ? IV_ONES : diff[IV_W-1:0];
        end
        else if (TIMER_WIDTH == IV_W) begin : g_eq
            assign iv_sat = diff;
        end
        else begin : g_ext
            assign iv_sat = {{(IV_W-TIMER_WIDTH){1'b0}}, diff};
        end
    endgenerate

    // count update with capped weight, a cap of zero acts as one
    assign cap_eff   = (cap_reg == '0) ? CAP_W'(1) : cap_reg;
    assign n_new     = {1'b0, count_reg} + N_W'(1);
    assign count_new = (n_new >= {1'b0, cap_eff}) ? (cap_eff - CAP_W'(1))
                                                  : n_new[CAP_W-1:0];

    // operand select for the shared adder
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            ST_BIAS:
            begin
                alu_a = SUM_W'(iv_reg);
                alu_b = SUM_W'(n_reg >> 1);
            end
            ST_MUL:
            begin
                alu_a = acc_reg;
                alu_b = mplier_reg[0] ? mcand_reg : '0;
            end
            ST_DIV:
            begin
                alu_a   = SUM_W'({rem_reg, acc_reg[SUM_W-1]});
                alu_b   = SUM_W'(n_reg);
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    assign alu_res   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                     + (SUM_W+1)'(alu_sub);
    assign alu_carry = alu_res[SUM_W];

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        mplier_next = mplier_reg;
        mcand_next  = mcand_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        avg_next    = avg_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next  = ST_BIAS;
                    mplier_next = count_reg;
                    mcand_next  = SUM_W'(avg_reg);
                end
            end
            ST_BIAS:
            begin
                acc_next   = alu_res[SUM_W-1:0];
                step_next  = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                acc_next    = alu_res[SUM_W-1:0];
                mplier_next = mplier_reg >> 1;
                mcand_next  = mcand_reg << 1;
                step_next   = step_reg + STEP_W'(1);
                if (step_reg == MUL_LAST)
                begin
                    step_next  = '0;
                    rem_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                acc_next  = {acc_reg[SUM_W-2:0], alu_carry};
                rem_next  = alu_carry ? alu_res[N_W-1:0]
                                      : {rem_reg[N_W-2:0], acc_reg[SUM_W-1]};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == DIV_LAST)
                begin
                    avg_next   = acc_next[IV_W-1:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and statistic registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            cap_reg   <= CAP_RESET;
            prev_reg  <= '0;
            count_reg <= '0;
            avg_reg   <= '0;
            max_reg   <= '0;
            min_reg   <= IV_ONES;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            avg_reg   <= avg_next;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                prev_reg  <= timer_now;
                count_reg <= count_new;
                if (iv_sat > max_reg)
                begin
                    max_reg <= iv_sat;
                end
                if (iv_sat < min_reg)
                begin
                    min_reg <= iv_sat;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        mplier_reg <= mplier_next;
        mcand_reg  <= mcand_next;
        acc_reg    <= acc_next;
        rem_reg    <= rem_next;
        if (accept)
        begin
            iv_reg <= iv_sat;
            n_reg  <= n_new;
        end
    end

endmodule
